// ===== rtl/core/opc_pkg.sv =====
package opc_pkg;

   // Pixel format codes
   localparam logic [3:0] FMT_DIRECT32   = 4'd0;
   localparam logic [3:0] FMT_TRUE24     = 4'd1;
   localparam logic [3:0] FMT_TRUE24_PK  = 4'd2;
   localparam logic [3:0] FMT_ALPHA15    = 4'd3;
   localparam logic [3:0] FMT_HI16       = 4'd4;
   localparam logic [3:0] FMT_HI15       = 4'd5;
   localparam logic [3:0] FMT_HI16_ALT7  = 4'd7;
   localparam logic [3:0] FMT_HI16_ALT10 = 4'd10;
   localparam logic [3:0] FMT_HI16_ALT11 = 4'd11;

   // Alpha modes
   localparam logic [1:0] AMODE_EMBEDDED = 2'd0;
   localparam logic [1:0] AMODE_GLOBAL   = 2'd1;
   localparam logic [1:0] AMODE_MULTIPLY = 2'd2;
   localparam logic [1:0] AMODE_EMB_ALT  = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_OVERLAY_FORMAT = 3'd0;
   localparam logic [2:0] REG_OUTPUT_FORMAT  = 3'd1;
   localparam logic [2:0] REG_ALPHA_MODE     = 3'd2;
   localparam logic [2:0] REG_GLOBAL_ALPHA   = 3'd3;
   localparam logic [2:0] REG_KEY_ENABLE     = 3'd4;
   localparam logic [2:0] REG_KEY_LOW        = 3'd5;
   localparam logic [2:0] REG_KEY_HIGH       = 3'd6;

   localparam logic [31:0] OPAQUE_BLACK = 32'hff00_0000;
   localparam logic [7:0]  ALPHA_MAX    = 8'd255;
   localparam logic [15:0] ROUND_BIAS   = 16'd127;

   typedef logic [7:0] chan_type;

   typedef struct packed {
      chan_type a;
      chan_type r;
      chan_type g;
      chan_type b;
   } argb_type;

   function automatic logic fmt_known(input logic [3:0] f);
      logic k;
      case (f) inside
         [FMT_DIRECT32:FMT_HI15], FMT_HI16_ALT7, FMT_HI16_ALT10, FMT_HI16_ALT11: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

   function automatic chan_type widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic chan_type widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // Raw pixel word to ARGB8888; unknown formats read as opaque black
   function automatic argb_type unpack(input logic [3:0] f, input logic [31:0] w);
      argb_type p;
      p = OPAQUE_BLACK;
      case (f) inside
         FMT_DIRECT32: p = w;
         FMT_TRUE24, FMT_TRUE24_PK: p = {8'hff, w[23:0]};
         FMT_ALPHA15, FMT_HI15: begin
            p.a = (f == FMT_ALPHA15 && !w[15]) ? 8'h00 : 8'hff;
            p.r = widen5(w[14:10]);
            p.g = widen5(w[9:5]);
            p.b = widen5(w[4:0]);
         end
         FMT_HI16, FMT_HI16_ALT7, FMT_HI16_ALT10, FMT_HI16_ALT11: begin
            p.a = 8'hff;
            p.r = widen5(w[15:11]);
            p.g = widen6(w[10:5]);
            p.b = widen5(w[4:0]);
         end
         default: p = OPAQUE_BLACK;
      endcase
      return p;
   endfunction

   // ARGB8888 to raw pixel word; anything not listed packs as RGB565
   function automatic logic [31:0] pack(input logic [3:0] f, input argb_type p);
      logic [31:0] w;
      case (f) inside
         FMT_DIRECT32: w = p;
         FMT_TRUE24, FMT_TRUE24_PK: w = {8'h00, p[23:0]};
         FMT_ALPHA15: w = {16'h0000, p.a[7], p.r[7:3], p.g[7:3], p.b[7:3]};
         FMT_HI15:    w = {16'h0000, 1'b0, p.r[7:3], p.g[7:3], p.b[7:3]};
         default:     w = {16'h0000, p.r[7:3], p.g[7:2], p.b[7:3]};
      endcase
      return w;
   endfunction

   // Floor of x / 255, exact for every 16-bit x used here
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== rtl/core/overlay_pixel_compositor.sv =====
// Overlay pixel compositor: takes one overlay/destination pixel pair per beat and returns one
// blended pixel per beat. It is a four-stage pipeline (unpack and key test, alpha select,
// channel multiply, divide by 255 and repack), so the throughput is one pixel per clock
// unless a stalled response is held at the output. A stall on the
// response side freezes every stage at once; bubbles are not squeezed out. Configuration
// registers feed the stages directly and may only be written while the pipeline is empty.
// A response with write_enable low (color-keyed or unknown output format) carries a zero word.
module overlay_pixel_compositor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_overlay_raw,
   input  logic [31:0] req_dest_raw,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_raw,
   output logic        rsp_write_enable,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data
);
   import opc_pkg::*;

   // Configuration registers
   logic [3:0]  ovl_fmt_ff, out_fmt_ff;
   logic [1:0]  amode_ff;
   logic [7:0]  galpha_ff;
   logic        key_en_ff;
   logic [23:0] key_lo_ff, key_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovl_fmt_ff <= '0;
         out_fmt_ff <= '0;
         amode_ff   <= '0;
         galpha_ff  <= '0;
         key_en_ff  <= 1'b0;
         key_lo_ff  <= '0;
         key_hi_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_OVERLAY_FORMAT: ovl_fmt_ff <= csr_write_data[3:0];
            REG_OUTPUT_FORMAT:  out_fmt_ff <= csr_write_data[3:0];
            REG_ALPHA_MODE:     amode_ff   <= csr_write_data[1:0];
            REG_GLOBAL_ALPHA:   galpha_ff  <= csr_write_data[7:0];
            REG_KEY_ENABLE:     key_en_ff  <= csr_write_data[0];
            REG_KEY_LOW:        key_lo_ff  <= csr_write_data;
            REG_KEY_HIGH:       key_hi_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Whole pipeline moves unless the output holds a stalled beat
   logic rsp_valid_ff;
   logic advance;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage 1: unpack, key test, embedded * global product
   argb_type    s1_src_ff, s1_dst_ff, s1_src_in, s1_dst_in;
   logic        s1_valid_ff, s1_wr_ff, s1_wr_in;
   logic [15:0] s1_prod_ff, s1_prod_in;
   logic        key_hit;

   always_comb begin
      s1_src_in  = unpack(ovl_fmt_ff, req_overlay_raw);
      s1_dst_in  = unpack(out_fmt_ff, req_dest_raw);
      key_hit    = key_en_ff && (key_lo_ff <= key_hi_ff)
                   && (s1_src_in[23:0] >= key_lo_ff) && (s1_src_in[23:0] <= key_hi_ff);
      s1_wr_in   = fmt_known(out_fmt_ff) && !key_hit;
      s1_prod_in = 16'(s1_src_in.a * galpha_ff);
   end

   // Stage 2: alpha select
   argb_type s2_src_ff, s2_dst_ff;
   logic     s2_valid_ff, s2_wr_ff;
   chan_type s2_alpha_ff, s2_alpha_in;

   always_comb begin
      case (amode_ff)
         AMODE_GLOBAL:   s2_alpha_in = galpha_ff;
         AMODE_MULTIPLY: s2_alpha_in = div255(s1_prod_ff);
         default:        s2_alpha_in = s1_src_ff.a;
      endcase
   end

   // Stage 3: per-channel weighted sums with rounding bias
   logic        s3_valid_ff, s3_wr_ff, s3_zero_ff;
   chan_type    s3_dst_a_ff;
   logic [15:0] s3_sum_ff [3];
   logic [15:0] s3_sum_in [3];
   chan_type    inv_alpha;

   always_comb begin
      inv_alpha = ALPHA_MAX - s2_alpha_ff;
      for (int i = 0; i < 3; i++) begin
         s3_sum_in[i] = 16'(s2_src_ff[i*8 +: 8] * s2_alpha_ff
                          + s2_dst_ff[i*8 +: 8] * inv_alpha + ROUND_BIAS);
      end
   end

   // Stage 4: divide by 255, repack, gate with write flag
   logic        rsp_wr_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;
   argb_type    blend;

   always_comb begin
      blend.a = s3_zero_ff ? s3_dst_a_ff : 8'hff;
      blend.r = div255(s3_sum_ff[2]);
      blend.g = div255(s3_sum_ff[1]);
      blend.b = div255(s3_sum_ff[0]);
      rsp_data_in = s3_wr_ff ? pack(out_fmt_ff, blend) : 32'd0;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_src_ff   <= s1_src_in;
         s1_dst_ff   <= s1_dst_in;
         s1_wr_ff    <= s1_wr_in;
         s1_prod_ff  <= s1_prod_in;
         s2_src_ff   <= s1_src_ff;
         s2_dst_ff   <= s1_dst_ff;
         s2_wr_ff    <= s1_wr_ff;
         s2_alpha_ff <= s2_alpha_in;
         s3_wr_ff    <= s2_wr_ff;
         s3_zero_ff  <= (s2_alpha_ff == 8'd0);
         s3_dst_a_ff <= s2_dst_ff.a;
         for (int i = 0; i < 3; i++) begin
            s3_sum_ff[i] <= s3_sum_in[i];
         end
         rsp_wr_ff   <= s3_wr_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_raw   = rsp_data_ff;
   assign rsp_write_enable = rsp_wr_ff;

   // A suppressed write always carries a zero word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_result_raw == 32'd0)
      else $error("non-zero word on suppressed write");

   // An accepted request lands in stage 1
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted beat lost at stage 1");

   // A beat in stage 3 reaches the output whenever the pipeline advances
   assert property (@(posedge clock) disable iff (reset)
      advance && s3_valid_ff |=> rsp_valid)
      else $error("beat lost between stage 3 and output");

   // Frozen pipeline keeps its stage valids
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff))
      else $error("stage valid changed while stalled");

endmodule

// ===== tb/sv/tb_overlay_pixel_compositor.sv =====
`timescale 1ns / 1ps

module tb_overlay_pixel_compositor;
   import opc_pkg::*;

   // Unknown format codes used on purpose
   localparam logic [3:0] FMT_BAD_6  = 4'd6;
   localparam logic [3:0] FMT_BAD_8  = 4'd8;
   localparam logic [3:0] FMT_BAD_15 = 4'd15;

   localparam int PHASES       = 14;
   localparam int PHASE_PIXELS = 125;
   localparam int HOLD_CYCLES  = 64;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [3:0]  ovl_fmt;
      logic [3:0]  out_fmt;
      logic [1:0]  amode;
      logic [7:0]  galpha;
      logic        key_en;
      logic [23:0] key_lo;
      logic [23:0] key_hi;
   } comp_setup_type;

   typedef struct packed {
      logic [31:0] result;
      logic        write;
   } blend_out_type;

   typedef struct packed {
      comp_setup_type setup;
      logic [31:0]    ovl;
      logic [31:0]    dst;
      logic           typed;
      blend_out_type  want;
   } directed_row_type;

   // Directed pixels; typed rows carry their answer, the rest go through the predictor
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      // reset setup: opaque, transparent, partial, extremes
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hff12_3456, 32'h89ab_cdef, 1'b1, '{32'hff12_3456, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h00ab_cdef, 32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h80ff_0000, 32'h0000_ff00, 1'b0, '{32'h0, 1'b0}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hffff_ffff, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h0000_0000, 32'hffff_ffff, 1'b1, '{32'hffff_ffff, 1'b1}},
      // unknown output format suppresses the write
      '{'{FMT_DIRECT32, FMT_BAD_15, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hff11_2233, 32'h4455_6677, 1'b1, '{32'h0, 1'b0}},
      '{'{FMT_DIRECT32, FMT_BAD_6, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h8011_2233, 32'hffff_ffff, 1'b1, '{32'h0, 1'b0}},
      // unknown overlay format reads as opaque black
      '{'{FMT_BAD_15, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h1234_5678, 32'h9abc_def0, 1'b1, '{32'hff00_0000, 1'b1}},
      '{'{FMT_BAD_8, FMT_TRUE24, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hffff_ffff, 32'h00ff_ffff, 1'b1, '{32'h0000_0000, 1'b1}},
      // every known format on at least one side
      '{'{FMT_TRUE24, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'haa12_3456, 32'h0f0f_0f0f, 1'b1, '{32'hff12_3456, 1'b1}},
      '{'{FMT_TRUE24_PK, FMT_TRUE24_PK, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h00fe_dcba, 32'h1111_1111, 1'b1, '{32'h00fe_dcba, 1'b1}},
      '{'{FMT_ALPHA15, FMT_ALPHA15, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h0000_ffff, 32'h0000_0000, 1'b1, '{32'h0000_ffff, 1'b1}},
      '{'{FMT_ALPHA15, FMT_ALPHA15, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h0000_7fff, 32'h0000_8421, 1'b1, '{32'h0000_8421, 1'b1}},
      '{'{FMT_HI16, FMT_HI16, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h0000_ffff, 32'h0000_1234, 1'b1, '{32'h0000_ffff, 1'b1}},
      '{'{FMT_HI15, FMT_HI16_ALT7, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'h1234_5678, 32'h9abc_def0, 1'b0, '{32'h0, 1'b0}},
      '{'{FMT_HI16_ALT10, FMT_HI16_ALT11, AMODE_EMBEDDED, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hcafe_b0ba, 32'h0bad_f00d, 1'b0, '{32'h0, 1'b0}},
      // alpha modes
      '{'{FMT_DIRECT32, FMT_HI15, AMODE_GLOBAL, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hdead_beef, 32'h1234_5678, 1'b0, '{32'h0, 1'b0}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_GLOBAL, 8'd255, 1'b0, 24'h0, 24'h0},
        32'h0012_3456, 32'h0000_0000, 1'b1, '{32'hff12_3456, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_MULTIPLY, 8'd128, 1'b0, 24'h0, 24'h0},
        32'h80ff_8040, 32'h0010_2030, 1'b0, '{32'h0, 1'b0}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_MULTIPLY, 8'd255, 1'b0, 24'h0, 24'h0},
        32'hff65_4321, 32'h0000_0000, 1'b1, '{32'hff65_4321, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMB_ALT, 8'd0, 1'b0, 24'h0, 24'h0},
        32'hffab_cdef, 32'h0000_0000, 1'b1, '{32'hffab_cdef, 1'b1}},
      // color key: single-point range hit and miss, inverted range, full range
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b1, 24'h12_3456, 24'h12_3456},
        32'hff12_3456, 32'h0000_0000, 1'b1, '{32'h0, 1'b0}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b1, 24'h12_3456, 24'h12_3456},
        32'hff12_3457, 32'h0000_0000, 1'b1, '{32'hff12_3457, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b1, 24'hff_ffff, 24'h00_0000},
        32'hff00_0000, 32'h1234_5678, 1'b1, '{32'hff00_0000, 1'b1}},
      '{'{FMT_DIRECT32, FMT_DIRECT32, AMODE_EMBEDDED, 8'd0, 1'b1, 24'h00_0000, 24'hff_ffff},
        32'h00ab_cdef, 32'h1234_5678, 1'b1, '{32'h0, 1'b0}}
   };

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [31:0] req_overlay_raw  = '0;
   logic [31:0] req_dest_raw     = '0;
   logic        rsp_stall        = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = '0;
   logic [23:0] csr_write_data   = '0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [31:0] rsp_result_raw;
   wire         rsp_write_enable;

   comp_setup_type live_setup = '0;
   blend_out_type  pending_pixels[$];
   int unsigned    gap_pct = 0;
   int unsigned    stall_pct = 0;
   int unsigned    holds_asked = 0;
   int unsigned    mismatches = 0;
   int unsigned    pixels_sent = 0;
   int unsigned    results_checked = 0;
   int unsigned    setups_applied = 0;

   overlay_pixel_compositor DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_overlay_raw  (req_overlay_raw),
      .req_dest_raw     (req_dest_raw),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_raw   (rsp_result_raw),
      .rsp_write_enable (rsp_write_enable),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- pixel predictor ----------------

   function automatic bit known_format(logic [3:0] f);
      return f <= FMT_HI15 || f == FMT_HI16_ALT7 || f == FMT_HI16_ALT10 ||
             f == FMT_HI16_ALT11;
   endfunction

   function automatic logic [7:0] stretch5(logic [4:0] v);
      return (8'(v) << 3) | (8'(v) >> 2);
   endfunction

   function automatic logic [7:0] stretch6(logic [5:0] v);
      return (8'(v) << 2) | (8'(v) >> 4);
   endfunction

   // Raw word to ARGB8888
   function automatic logic [31:0] expand_pixel(logic [3:0] f, logic [31:0] w);
      logic [7:0] a;
      a = 8'hff;
      if (!known_format(f))
         return OPAQUE_BLACK;
      case (f)
         FMT_DIRECT32: return w;
         FMT_TRUE24, FMT_TRUE24_PK: return {8'hff, w[23:0]};
         FMT_ALPHA15, FMT_HI15: begin
            if (f == FMT_ALPHA15 && !w[15])
               a = 8'h00;
            return {a, stretch5(w[14:10]), stretch5(w[9:5]), stretch5(w[4:0])};
         end
         default: return {a, stretch5(w[15:11]), stretch6(w[10:5]), stretch5(w[4:0])};
      endcase
   endfunction

   // ARGB8888 to raw word; all other codes pack as RGB565
   function automatic logic [31:0] squeeze_pixel(logic [3:0] f, logic [31:0] p);
      case (f)
         FMT_DIRECT32: return p;
         FMT_TRUE24, FMT_TRUE24_PK: return {8'h00, p[23:0]};
         FMT_ALPHA15: return {16'h0000, p[31], p[23:19], p[15:11], p[7:3]};
         FMT_HI15: return {16'h0000, 1'b0, p[23:19], p[15:11], p[7:3]};
         default: return {16'h0000, p[23:19], p[15:10], p[7:3]};
      endcase
   endfunction

   // Per-channel blend with rounded divide by 255
   function automatic logic [31:0] mix_channels(logic [31:0] d, logic [31:0] s,
                                                logic [7:0] a);
      logic [31:0] res;
      int unsigned sc, dc, v;
      if (a == ALPHA_MAX)
         return s | OPAQUE_BLACK;
      if (a == 8'd0)
         return d;
      res = OPAQUE_BLACK;
      for (int i = 0; i < 3; i++) begin
         sc = s[i*8 +: 8];
         dc = d[i*8 +: 8];
         v = (sc * a + dc * (255 - a) + 127) / 255;
         res[i*8 +: 8] = v[7:0];
      end
      return res;
   endfunction

   function automatic blend_out_type composite_pixel(comp_setup_type c, logic [31:0] ovl,
                                                     logic [31:0] dst);
      logic [31:0]   src, back;
      logic [7:0]    a;
      blend_out_type r;
      src = expand_pixel(c.ovl_fmt, ovl);
      back = expand_pixel(c.out_fmt, dst);
      r.write = known_format(c.out_fmt);
      if (c.key_en && c.key_lo <= c.key_hi && src[23:0] >= c.key_lo && src[23:0] <= c.key_hi)
         r.write = 1'b0;
      case (c.amode)
         AMODE_GLOBAL:   a = c.galpha;
         AMODE_MULTIPLY: a = 8'((32'(src[31:24]) * 32'(c.galpha)) / 255);
         default:        a = src[31:24];
      endcase
      r.result = r.write ? squeeze_pixel(c.out_fmt, mix_channels(back, src, a)) : '0;
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic comp_setup_type random_setup();
      comp_setup_type c;
      // mostly known formats, sometimes any code
      do c.ovl_fmt = 4'($urandom_range(15));
      while (!known_format(c.ovl_fmt) && $urandom_range(3) != 0);
      do c.out_fmt = 4'($urandom_range(15));
      while (!known_format(c.out_fmt) && $urandom_range(3) != 0);
      c.amode = 2'($urandom_range(3));
      case ($urandom_range(3))
         0: c.galpha = 8'd0;
         1: c.galpha = ALPHA_MAX;
         default: c.galpha = 8'($urandom());
      endcase
      c.key_en = 1'($urandom_range(1));
      c.key_lo = 24'($urandom());
      case ($urandom_range(9))
         0, 1: c.key_hi = 24'($urandom_range(c.key_lo));
         2: begin
            c.key_lo = 24'h00_0000;
            c.key_hi = 24'hff_ffff;
         end
         default: c.key_hi = (c.key_lo > 24'hc0_0000) ? 24'hff_ffff :
                             c.key_lo + 24'($urandom_range(24'h3f_ffff));
      endcase
      return c;
   endfunction

   // Drop valid and wait until every expected pixel is back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (pending_pixels.size() != 0);
   endtask

   task automatic put_reg(logic [2:0] idx, logic [23:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
   endtask

   task automatic apply_setup(comp_setup_type c);
      drain_pipeline();
      put_reg(REG_OVERLAY_FORMAT, 24'(c.ovl_fmt));
      put_reg(REG_OUTPUT_FORMAT, 24'(c.out_fmt));
      put_reg(REG_ALPHA_MODE, 24'(c.amode));
      put_reg(REG_GLOBAL_ALPHA, 24'(c.galpha));
      put_reg(REG_KEY_ENABLE, 24'(c.key_en));
      put_reg(REG_KEY_LOW, c.key_lo);
      put_reg(REG_KEY_HIGH, c.key_hi);
      csr_write_enable <= 1'b0;
      live_setup = c;
      setups_applied++;
   endtask

   // One request beat; the expectation is queued when the beat is taken
   task automatic send_pixel(logic [31:0] ovl, logic [31:0] dst, logic typed,
                             blend_out_type typed_out);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_overlay_raw <= ovl;
      req_dest_raw <= dst;
      do @(posedge clock);
      while (!(req_valid && !req_stall));
      pending_pixels.push_back(typed ? typed_out : composite_pixel(live_setup, ovl, dst));
      pixels_sent++;
   endtask

   // ---------------- response side ----------------

   // Random stall, or a long hold-off when one is asked for
   int unsigned hold_left = 0;
   int unsigned holds_taken = 0;
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_taken != holds_asked) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         holds_taken <= holds_taken + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin : check_results
      blend_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result beat: result_raw %08h write_enable %0b",
                   rsp_result_raw, rsp_write_enable);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_result_raw !== want.result) begin
               $error("result_raw: expected %08h, got %08h", want.result, rsp_result_raw);
               mismatches++;
            end
            if (rsp_write_enable !== want.write) begin
               $error("write_enable: expected %0b, got %0b", want.write, rsp_write_enable);
               mismatches++;
            end
            results_checked++;
         end
      end
   end

   // Watchdog on cycles with no beat on either side
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------- main sequence ----------------

   initial begin : main_flow
      logic [31:0]   ovl, dst;
      idle_mode_type mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         if (DIRECTED_ROWS[i].setup != live_setup)
            apply_setup(DIRECTED_ROWS[i].setup);
         send_pixel(DIRECTED_ROWS[i].ovl, DIRECTED_ROWS[i].dst, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].want);
      end

      // random phases, each with its own setup and idle pattern
      for (int p = 0; p < PHASES; p++) begin
         apply_setup(random_setup());
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 61; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 61; end
            default:       begin gap_pct = 20; stall_pct = 20; end
         endcase
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // long receiver hold-off while requests keep coming
            if (p == 2 && n == 20)
               holds_asked <= holds_asked + 1;
            // sender pause until the pipeline is empty
            if (p == 4 && n == 60)
               drain_pipeline();
            ovl = $urandom();
            dst = $urandom();
            case ($urandom_range(9))
               0: ovl[31:24] = 8'h00;
               1: ovl[31:24] = ALPHA_MAX;
               2: ovl[23:0] = live_setup.key_lo;
               3: ovl[23:0] = live_setup.key_hi;
               default: ;
            endcase
            send_pixel(ovl, dst, 1'b0, '0);
         end
      end

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d pixels over %0d register setups, %0d results checked,",
               pixels_sent, setups_applied, results_checked);
      $display("with all formats, alpha modes, color-key ranges and idle patterns.");
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/opc_pkg.sv
rtl/core/overlay_pixel_compositor.sv
tb/sv/tb_overlay_pixel_compositor.sv
